// ===== sv/u8u16_pkg.sv =====
package u8u16_pkg;

   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH        = 4;
   localparam int CAP_W              = 24;
   localparam int INDEX_W            = 24;

   localparam logic [CAP_W-1:0] CAP_RESET   = 24'hFFFFFF;
   localparam logic [15:0]      REPL_UNIT   = 16'hFFFD;
   localparam logic [15:0]      SURR_HIGH   = 16'hD800;
   localparam logic [15:0]      SURR_LOW    = 16'hDC00;
   localparam logic [20:0]      SUPP_BASE   = 21'h010000;
   localparam logic [20:0]      MAX_POINT   = 21'h10FFFF;
   localparam logic [20:0]      MIN_TWO     = 21'h000080;
   localparam logic [20:0]      MIN_THREE   = 21'h000800;
   localparam logic [20:0]      SURR_FIRST  = 21'h00D800;
   localparam logic [20:0]      SURR_LAST   = 21'h00DFFF;

   // continuation bytes expected by a pending sequence
   localparam logic [1:0] EXP_NONE  = 2'd0;
   localparam logic [1:0] EXP_ONE   = 2'd1;
   localparam logic [1:0] EXP_TWO   = 2'd2;
   localparam logic [1:0] EXP_THREE = 2'd3;

   // one decoded byte: a run of replacements followed by up to two point units
   typedef struct packed {
      logic [2:0]  n_repl;
      logic [1:0]  n_pt;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        end_text;
   } job_type;

endpackage

// ===== sv/utf8_to_utf16_transcoder_top.sv =====
// path: an accepted byte's units are written into the job queue, then into the rsp output register
// throughput: one byte per cycle while each byte gives at most one unit and rsp_pop keeps up;
//   a byte with n units holds the unit stage for each; a four-entry job queue absorbs the burst
// the unit stage emits one UTF-16 unit per cycle, when not stalled, into a single output register
// reset: sequence state, unit index, job queue and output valid clear; capacity is all ones
module utf8_to_utf16_transcoder_top #(
   parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [7:0]                     req_byte_in,
   input  logic                           req_end_of_text,
   output logic                           req_full,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output logic [15:0]                    rsp_code_unit,
   output logic                           rsp_is_replacement,
   output logic [u8u16_pkg::INDEX_W-1:0]  rsp_unit_index,
   output logic                           rsp_stored,
   output logic                           rsp_last_of_run,
   output logic                           rsp_text_done,
   input  logic                           csr_write_enable,
   input  logic [u8u16_pkg::CAP_W-1:0]    csr_write_data
);
   import u8u16_pkg::*;

   logic    job_push;
   job_type job;
   job_type q_head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   u8u16_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_byte_in     (req_byte_in),
      .req_end_of_text (req_end_of_text),
      .req_full        (req_full),
      .q_full          (q_full),
      .job_push        (job_push),
      .job             (job)
   );

   u8u16_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (job_push),
      .q_wdata (job),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   u8u16_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_code_unit      (rsp_code_unit),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_unit_index     (rsp_unit_index),
      .rsp_stored         (rsp_stored),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_text_done      (rsp_text_done)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_text_done) |-> rsp_last_of_run)
      else $error("text_done without last_of_run");

   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_replacement) |-> (rsp_code_unit == REPL_UNIT))
      else $error("replacement flag on a unit other than U+FFFD");

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("job queue both full and empty");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from empty queue");

endmodule

// ===== sv/u8u16_front.sv =====
module u8u16_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_byte_in,
   input  logic                req_end_of_text,
   output logic                req_full,
   input  logic                q_full,
   output logic                job_push,
   output u8u16_pkg::job_type  job
);
   import u8u16_pkg::*;

   logic [20:0] gath_ff, gath_in;
   logic [1:0]  exp_ff, exp_in;
   logic [1:0]  taken_ff, taken_in;

   logic        accept;
   logic        is_cont;
   logic [2:0]  taken_n;
   logic [20:0] gath_n;
   logic [20:0] adj;
   logic        seq_done;
   logic        pt_ok;
   logic        lead_ascii;
   logic        lead_multi;
   logic [1:0]  lead_exp;
   logic [20:0] lead_bits;
   logic [2:0]  n_repl;
   logic [1:0]  n_pt;
   logic [15:0] unit0;
   logic [15:0] unit1;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign is_cont  = (req_byte_in[7:6] == 2'b10);
   assign taken_n  = {1'b0, taken_ff} + 3'd1;
   assign gath_n   = {gath_ff[14:0], req_byte_in[5:0]};
   assign adj      = gath_n - SUPP_BASE;
   assign seq_done = (taken_n >= {1'b0, exp_ff});

   always_comb begin
      lead_ascii = !req_byte_in[7];
      lead_multi = 1'b0;
      lead_exp   = EXP_NONE;
      lead_bits  = '0;
      if (req_byte_in[7:5] == 3'b110) begin
         lead_multi = 1'b1;
         lead_exp   = EXP_ONE;
         lead_bits  = {16'd0, req_byte_in[4:0]};
      end else if (req_byte_in[7:4] == 4'b1110) begin
         lead_multi = 1'b1;
         lead_exp   = EXP_TWO;
         lead_bits  = {17'd0, req_byte_in[3:0]};
      end else if (req_byte_in[7:3] == 5'b11110) begin
         lead_multi = 1'b1;
         lead_exp   = EXP_THREE;
         lead_bits  = {18'd0, req_byte_in[2:0]};
      end
   end

   // overlong, surrogate and out-of-range checks on the finished point
   always_comb begin
      case (exp_ff)
         EXP_ONE:   pt_ok = (gath_n >= MIN_TWO);
         EXP_TWO:   pt_ok = (gath_n >= MIN_THREE) &&
                            !((gath_n >= SURR_FIRST) && (gath_n <= SURR_LAST));
         EXP_THREE: pt_ok = (gath_n >= SUPP_BASE) && (gath_n <= MAX_POINT);
         default:   pt_ok = 1'b0;
      endcase
   end

   always_comb begin
      gath_in  = gath_ff;
      exp_in   = exp_ff;
      taken_in = taken_ff;
      n_repl   = 3'd0;
      n_pt     = 2'd0;
      unit0    = '0;
      unit1    = '0;
      if (accept) begin
         if ((exp_ff != EXP_NONE) && is_cont) begin
            if (seq_done) begin
               if (pt_ok) begin
                  if (gath_n < SUPP_BASE) begin
                     n_pt  = 2'd1;
                     unit0 = gath_n[15:0];
                  end else begin
                     n_pt  = 2'd2;
                     unit0 = SURR_HIGH + {6'd0, adj[19:10]};
                     unit1 = SURR_LOW + {6'd0, adj[9:0]};
                  end
               end else begin
                  n_repl = taken_n + 3'd1;
               end
               gath_in  = '0;
               exp_in   = EXP_NONE;
               taken_in = '0;
            end else if (req_end_of_text) begin
               n_repl = taken_n + 3'd1;
            end else begin
               gath_in  = gath_n;
               taken_in = taken_n[1:0];
            end
         end else begin
            // broken sequence: flush it, then the byte starts over as a lead
            if (exp_ff != EXP_NONE) begin
               n_repl   = {1'b0, taken_ff} + 3'd1;
               gath_in  = '0;
               exp_in   = EXP_NONE;
               taken_in = '0;
            end
            if (lead_ascii) begin
               n_pt  = 2'd1;
               unit0 = {8'd0, req_byte_in};
            end else if (lead_multi && !req_end_of_text) begin
               gath_in  = lead_bits;
               exp_in   = lead_exp;
               taken_in = '0;
            end else begin
               n_repl = n_repl + 3'd1;
            end
         end
         if (req_end_of_text) begin
            gath_in  = '0;
            exp_in   = EXP_NONE;
            taken_in = '0;
         end
      end
   end

   assign job_push     = accept && ((n_repl != 3'd0) || (n_pt != 2'd0));
   assign job.n_repl   = n_repl;
   assign job.n_pt     = n_pt;
   assign job.unit0    = unit0;
   assign job.unit1    = unit1;
   assign job.end_text = req_end_of_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         gath_ff  <= '0;
         exp_ff   <= EXP_NONE;
         taken_ff <= '0;
      end else begin
         gath_ff  <= gath_in;
         exp_ff   <= exp_in;
         taken_ff <= taken_in;
      end
   end

endmodule

// ===== sv/u8u16_queue.sv =====
module u8u16_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  u8u16_pkg::job_type  q_wdata,
   input  logic                q_pop,
   output u8u16_pkg::job_type  q_head,
   output logic                q_full,
   output logic                q_empty
);
   import u8u16_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign q_full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign q_head  = slot_ff[rd_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_in  = do_push ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/u8u16_back.sv =====
module u8u16_back #(
   parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [u8u16_pkg::CAP_W-1:0]        csr_write_data,
   input  logic                               q_empty,
   input  u8u16_pkg::job_type                 q_head,
   output logic                               q_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic [15:0]                        rsp_code_unit,
   output logic                               rsp_is_replacement,
   output logic [u8u16_pkg::INDEX_W-1:0]      rsp_unit_index,
   output logic                               rsp_stored,
   output logic                               rsp_last_of_run,
   output logic                               rsp_text_done
);
   import u8u16_pkg::*;

   localparam int CMP_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]            pos_ff, pos_in;
   logic                  valid_ff, valid_in;
   logic [15:0]           code_ff;
   logic                  repl_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic                  stored_ff;
   logic                  last_ff;
   logic                  done_ff;

   logic                  emit;
   logic [2:0]            total;
   logic                  is_last;
   logic                  in_repl;
   logic [2:0]            pt_sel;
   logic [15:0]           unit;
   logic [CMP_W-1:0]      idx_ext;
   logic [CMP_W-1:0]      cap_ext;

   assign total   = q_head.n_repl + {1'b0, q_head.n_pt};
   assign is_last = ({1'b0, pos_ff} == (total - 3'd1));
   assign in_repl = ({1'b0, pos_ff} < q_head.n_repl);
   assign pt_sel  = {1'b0, pos_ff} - q_head.n_repl;
   assign unit    = in_repl ? REPL_UNIT : (pt_sel[0] ? q_head.unit1 : q_head.unit0);
   assign idx_ext = CMP_W'(cnt_ff);
   assign cap_ext = CMP_W'(cap_ff);

   // output register refills whenever it is empty or being drained and a job is queued
   assign emit  = (!valid_ff || rsp_pop) && !q_empty;
   assign q_pop = emit && is_last;

   always_comb begin
      cap_in   = csr_write_enable ? csr_write_data : cap_ff;
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (emit) begin
         pos_in = is_last ? 2'd0 : pos_ff + 2'd1;
         if (is_last && q_head.end_text) begin
            cnt_in = '0;
         end else if (cnt_ff != '1) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff   <= unit;
         repl_ff   <= in_repl;
         idx_ff    <= idx_ext[INDEX_W-1:0];
         stored_ff <= (idx_ext < cap_ext);
         last_ff   <= is_last;
         done_ff   <= is_last && q_head.end_text;
      end
   end

   assign rsp_empty          = !valid_ff;
   assign rsp_code_unit      = code_ff;
   assign rsp_is_replacement = repl_ff;
   assign rsp_unit_index     = idx_ff;
   assign rsp_stored         = stored_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_text_done      = done_ff;

endmodule
